// ===== sv/mandel_pkg.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-depth package
// Shared types, fixed-point constants, register codes and helpers for the
// escape-depth engine.
// ----------------------------------------------------------------------------
package mandel_pkg;

    // Fixed-point formats: coordinates Q5.27, products Q10.54
    localparam int Q_W      = 32;
    localparam int Q_FRAC   = 27;
    localparam int PROD_W   = 64;
    localparam int PIX_W    = 10;
    localparam int DEPTH_W  = 8;

    // Escape threshold 5.0 in Q10.54
    localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(5) << 54;

    // Largest escape depth the result word can carry
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    // Register reset values
    localparam logic [Q_W-1:0] X_ORIGIN_RST = 32'd31676726;
    localparam logic [Q_W-1:0] Y_ORIGIN_RST = 32'd69793219;
    localparam logic [Q_W-1:0] X_STEP_RST   = 32'd262;
    localparam logic [Q_W-1:0] Y_STEP_RST   = 32'd262;

    // Register index codes (byte address / 4)
    typedef enum logic [1:0] {
        REG_X_ORIGIN = 2'd0,
        REG_Y_ORIGIN = 2'd1,
        REG_X_STEP   = 2'd2,
        REG_Y_STEP   = 2'd3
    } t_reg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL_CX,
        ST_MUL_CY,
        ST_C_DONE,
        ST_MUL_XX,
        ST_MUL_YY,
        ST_MUL_XY,
        ST_UPDATE,
        ST_HOLD
    } t_state;

    // Clamp a wide signed value to the Q5.27 range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] q_max;
        logic signed [PROD_W-1:0] q_min;
        q_max = PROD_W'(33'sh0_7FFF_FFFF);
        q_min = -(PROD_W'(33'sh0_8000_0000));
        if (v > q_max) begin
            return {1'b0, {(Q_W-1){1'b1}}};
        end else if (v < q_min) begin
            return {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            return v[Q_W-1:0];
        end
    endfunction

endpackage

// ===== sv/mandelbrot_escape_depth_unit.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-depth unit
// A pixel is accepted in IDLE, folded into the frame in REDUCE (one subtract
// at a time), c is formed in MUL_CX, MUL_CY and C_DONE, each iteration runs
// MUL_XX, MUL_YY, MUL_XY and UPDATE, and HOLD loads the result word once free.
// No new pixel is taken until the last result is loaded; the single 32x32
// multiplier serves x*x, y*y and x*y in turn each iteration.
// Reset (synchronous, active low) idles the sequencer, drops any pending
// result word and loads the default origin and step registers.
// ----------------------------------------------------------------------------
module mandelbrot_escape_depth_unit #(
    parameter int MAX_ITER = 256,
    parameter int MAX_DIM  = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [mandel_pkg::PIX_W-1:0]      i_pixel_row,
    input  logic [mandel_pkg::PIX_W-1:0]      i_pixel_col,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mandel_pkg::DEPTH_W-1:0]    o_escape_depth,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int DW    = $clog2(MAX_ITER + 1);
    localparam int EW    = (DW > mandel_pkg::DEPTH_W) ? DW : mandel_pkg::DEPTH_W;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CW    = (DIM_W > mandel_pkg::PIX_W) ? DIM_W : mandel_pkg::PIX_W;
    localparam int QW    = mandel_pkg::Q_W;
    localparam int PW    = mandel_pkg::PROD_W;

    // control state
    mandel_pkg::t_state r_state, n_state;
    logic                r_out_valid, n_out_valid;

    // configuration registers
    logic [QW-1:0] r_x_origin, r_y_origin, r_x_step, r_y_step;

    // datapath registers
    logic [mandel_pkg::PIX_W-1:0]   r_row, n_row;
    logic [mandel_pkg::PIX_W-1:0]   r_col, n_col;
    logic signed [QW-1:0]           r_cx, n_cx;
    logic signed [QW-1:0]           r_cy, n_cy;
    logic signed [QW-1:0]           r_x, n_x;
    logic signed [QW-1:0]           r_y, n_y;
    logic signed [PW-1:0]           r_prod, n_prod;
    logic signed [PW-1:0]           r_xx, n_xx;
    logic signed [PW-1:0]           r_yy, n_yy;
    logic [DW-1:0]                  r_depth, n_depth;
    logic [mandel_pkg::DEPTH_W-1:0] r_out, n_out;

    // shared multiplier operands
    logic signed [QW-1:0] mul_a;
    logic signed [QW-1:0] mul_b;

    // helper terms
    logic [CW-1:0]        row_ext, col_ext, dim_c;
    logic                 row_big, col_big;
    logic [PW-1:0]        mag;
    logic signed [PW-1:0] diff_sh;
    logic signed [PW-1:0] xy_sh;
    logic signed [PW-1:0] new_x_wide;
    logic signed [PW-1:0] new_y_wide;
    logic signed [PW-1:0] cx_wide;
    logic signed [PW-1:0] cy_wide;
    logic [DW-1:0]        depth_dec;
    logic [EW-1:0]        depth_ext;
    logic                 done_iter;
    logic                 cfg_wr;

    // APB: always ready, write on access phase
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    // register read mux
    always_comb begin
        unique case (mandel_pkg::t_reg_idx'(paddr[3:2]))
            mandel_pkg::REG_X_ORIGIN: prdata = r_x_origin;
            mandel_pkg::REG_Y_ORIGIN: prdata = r_y_origin;
            mandel_pkg::REG_X_STEP:   prdata = r_x_step;
            mandel_pkg::REG_Y_STEP:   prdata = r_y_step;
            default:                  prdata = '0;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin <= mandel_pkg::X_ORIGIN_RST;
            r_y_origin <= mandel_pkg::Y_ORIGIN_RST;
            r_x_step   <= mandel_pkg::X_STEP_RST;
            r_y_step   <= mandel_pkg::Y_STEP_RST;
        end else if (cfg_wr) begin
            unique case (mandel_pkg::t_reg_idx'(paddr[3:2]))
                mandel_pkg::REG_X_ORIGIN: r_x_origin <= pwdata;
                mandel_pkg::REG_Y_ORIGIN: r_y_origin <= pwdata;
                mandel_pkg::REG_X_STEP:   r_x_step   <= pwdata;
                mandel_pkg::REG_Y_STEP:   r_y_step   <= pwdata;
                default: ;
            endcase
        end
    end

    // handshake outputs
    assign o_ready        = (r_state == mandel_pkg::ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_escape_depth = r_out;

    // frame folding compares
    assign row_ext = CW'(r_row);
    assign col_ext = CW'(r_col);
    assign dim_c   = CW'(MAX_DIM);
    assign row_big = (row_ext >= dim_c);
    assign col_big = (col_ext >= dim_c);

    // shared multiplier operand select
    always_comb begin
        mul_a = r_x;
        mul_b = r_x;
        case (r_state)
            mandel_pkg::ST_MUL_CX: begin
                mul_a = $signed(QW'(r_col));
                mul_b = $signed(r_x_step);
            end
            mandel_pkg::ST_MUL_CY: begin
                mul_a = $signed(QW'(r_row));
                mul_b = $signed(r_y_step);
            end
            mandel_pkg::ST_MUL_YY: begin
                mul_a = r_y;
                mul_b = r_y;
            end
            mandel_pkg::ST_MUL_XY: begin
                mul_a = r_x;
                mul_b = r_y;
            end
            default: begin
                mul_a = r_x;
                mul_b = r_x;
            end
        endcase
    end

    assign n_prod = PW'(mul_a) * PW'(mul_b);

    // point forming and iteration update terms
    assign cx_wide    = PW'(signed'(r_x_origin)) + r_prod;
    assign cy_wide    = PW'(signed'(r_y_origin)) + r_prod;
    assign mag        = PW'(r_xx) + PW'(r_yy);
    assign diff_sh    = (r_xx - r_yy) >>> mandel_pkg::Q_FRAC;
    assign xy_sh      = r_prod >>> (mandel_pkg::Q_FRAC - 1);
    assign new_x_wide = diff_sh + PW'(r_cx);
    assign new_y_wide = xy_sh + PW'(r_cy);
    assign depth_dec  = r_depth - DW'(1);
    assign done_iter  = (depth_dec == '0) || (mag >= mandel_pkg::ESC_LIMIT);
    assign depth_ext  = EW'(r_depth);

    // sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_row       = r_row;
        n_col       = r_col;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_x         = r_x;
        n_y         = r_y;
        n_xx        = r_xx;
        n_yy        = r_yy;
        n_depth     = r_depth;
        n_out       = r_out;

        // drop the result word once taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            mandel_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_row   = i_pixel_row;
                    n_col   = i_pixel_col;
                    n_state = mandel_pkg::ST_REDUCE;
                end
            end
            mandel_pkg::ST_REDUCE: begin
                // fold indices into the frame one subtract per cycle
                if (row_big) begin
                    n_row = r_row - mandel_pkg::PIX_W'(MAX_DIM);
                end
                if (col_big) begin
                    n_col = r_col - mandel_pkg::PIX_W'(MAX_DIM);
                end
                if (!row_big && !col_big) begin
                    n_state = mandel_pkg::ST_MUL_CX;
                end
            end
            mandel_pkg::ST_MUL_CX: begin
                n_state = mandel_pkg::ST_MUL_CY;
            end
            mandel_pkg::ST_MUL_CY: begin
                n_cx    = mandel_pkg::sat_q(cx_wide);
                n_x     = mandel_pkg::sat_q(cx_wide);
                n_state = mandel_pkg::ST_C_DONE;
            end
            mandel_pkg::ST_C_DONE: begin
                n_cy    = mandel_pkg::sat_q(cy_wide);
                n_y     = mandel_pkg::sat_q(cy_wide);
                n_depth = DW'(MAX_ITER);
                n_state = mandel_pkg::ST_MUL_XX;
            end
            mandel_pkg::ST_MUL_XX: begin
                n_state = mandel_pkg::ST_MUL_YY;
            end
            mandel_pkg::ST_MUL_YY: begin
                n_xx    = r_prod;
                n_state = mandel_pkg::ST_MUL_XY;
            end
            mandel_pkg::ST_MUL_XY: begin
                n_yy    = r_prod;
                n_state = mandel_pkg::ST_UPDATE;
            end
            mandel_pkg::ST_UPDATE: begin
                // advance z and count down; stop on escape or limit
                n_x     = mandel_pkg::sat_q(new_x_wide);
                n_y     = mandel_pkg::sat_q(new_y_wide);
                n_depth = depth_dec;
                n_state = done_iter ? mandel_pkg::ST_HOLD : mandel_pkg::ST_MUL_XX;
            end
            mandel_pkg::ST_HOLD: begin
                // load the result word when the output register is free
                if (!r_out_valid || i_ready) begin
                    if (depth_ext > EW'(mandel_pkg::DEPTH_MAX)) begin
                        n_out = mandel_pkg::DEPTH_MAX;
                    end else begin
                        n_out = depth_ext[mandel_pkg::DEPTH_W-1:0];
                    end
                    n_out_valid = 1'b1;
                    n_state     = mandel_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mandel_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mandel_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_col   <= n_col;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_x     <= n_x;
        r_y     <= n_y;
        r_prod  <= n_prod;
        r_xx    <= n_xx;
        r_yy    <= n_yy;
        r_depth <= n_depth;
        r_out   <= n_out;
    end

endmodule
